// ===== rtl/ape_nlms_sign_filter_stage_defines.svh =====
// assertion macros for the sign-sign adaptive filter stage
// used by the top level; expects aclk and aresetn in scope
`ifndef APE_NLMS_SIGN_FILTER_STAGE_DEFINES_SVH
`define APE_NLMS_SIGN_FILTER_STAGE_DEFINES_SVH

// condition holds in the same cycle
`define ANSF_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define ANSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ansf_pkg.sv =====
// shared types, widths and constants of the sign-sign adaptive filter stage
// no dependencies
package ansf_pkg;

    localparam int MAX_TAPS   = 1280;
    localparam int ADDR_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W      = $clog2(MAX_TAPS + 1);
    localparam int MIN_ORDER  = 16;

    localparam int ORDER_W    = 11;
    localparam int FRAC_W     = 4;
    localparam int COEF_W     = 16;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_ADAPTATION = 2'd2;

    localparam logic [ORDER_W-1:0] ORDER_RST = 11'd16;
    localparam logic [FRAC_W-1:0]  FRAC_RST  = 4'd11;

    // step rules
    localparam logic [COEF_W-1:0] OLD_STEP      = 16'd4;
    localparam logic [COEF_W-1:0] NEW_STEP_BASE = 16'((32'd1 << 30) >> 25);
    localparam int                AVG_SHIFT     = 4;

    // halving offsets below the order
    localparam int OLD_HALVE_A = 5;
    localparam int OLD_HALVE_B = 9;
    localparam int NEW_HALVE_A = 2;
    localparam int NEW_HALVE_B = 3;
    localparam int NEW_HALVE_C = 9;
    localparam logic [1:0] OLD_HALVE_LAST = 2'd1;
    localparam logic [1:0] NEW_HALVE_LAST = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_ROUND,
        ST_SUM,
        ST_NEWSTEP,
        ST_HRD,
        ST_HWR,
        ST_OUT
    } state_t;

    function automatic logic [COEF_W-1:0] halve16(input logic [COEF_W-1:0] v);
        return {v[COEF_W-1], v[COEF_W-1:1]};
    endfunction

endpackage

// ===== rtl/ape_nlms_sign_filter_stage.sv =====
// top level of one sign-sign adaptive filter stage for lossless audio decoding
// depends on ansf_pkg, ansf_ram and ape_nlms_sign_filter_stage_defines.svh
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  s_tdata = residual, s_tuser = clear_history
//   m_*       out        m_tvalid / m_tready  m_tdata = sample
//   cfg_*     in         cfg_wr_en            cfg_addr, cfg_wr_data
//
// one item runs one pass over its taps; the newer step rule runs one more halving
// round than the older one; the single multiply-accumulate unit visits one tap per cycle
// an item with clear_history set adds a zero sweep over the whole depth of the three rams
// after reset the same sweep runs before the first transfer is taken
// a result waits in the output register; a new transfer is taken meanwhile, and
// the sequencer only holds in its last state while that register is still full

`include "ape_nlms_sign_filter_stage_defines.svh"

module ape_nlms_sign_filter_stage
    import ansf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,     // [31:0] residual
    input  logic                  s_tuser,     // [0] clear_history

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,     // [31:0] sample

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    // configuration registers
    logic [ORDER_W-1:0] order_cfg_reg;
    logic [FRAC_W-1:0]  frac_cfg_reg;
    logic               new_adapt_cfg_reg;

    // sequencer and per-item state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;          // issue index or sweep index
    logic [CNT_W-1:0]   ord_reg, ord_next;          // clamped order of this item
    logic               item_pend_reg, item_pend_next;
    logic [1:0]         halve_cnt_reg, halve_cnt_next;
    logic [DATA_W-1:0]  avg_reg, avg_next;          // running mean magnitude

    // mac pipeline
    logic               v1_reg, v1_next;            // ram read data valid
    logic [ADDR_W-1:0]  idx1_reg, idx1_next;        // tap index of that read data
    logic               v2_reg, v2_next;            // product valid
    logic signed [DATA_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0]  acc_reg, acc_next;
    logic [DATA_W-1:0]  resid_reg, resid_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;

    // ram ports
    logic               w_we, h_we, st_we;
    logic [ADDR_W-1:0]  w_waddr, h_waddr, st_waddr;
    logic [COEF_W-1:0]  w_wdata, h_wdata, st_wdata;
    logic [ADDR_W-1:0]  mac_raddr, st_raddr;
    logic [COEF_W-1:0]  w_rd, h_rd, st_rd;

    // derived values
    logic [31:0]        ord_cfg_wide;
    logic [CNT_W-1:0]   ord_clamped;
    logic [CNT_W-1:0]   ord_m1, halve_pos;
    logic [ADDR_W-1:0]  halve_addr;
    logic [COEF_W-1:0]  w_upd;
    logic [DATA_W-1:0]  rnd_term, rnd_sum;
    logic [DATA_W-1:0]  mag;
    logic [DATA_W+1:0]  mag_x3, avg_x3, avg_x4;
    logic               le3, le43;
    logic [1:0]         step_shift;
    logic [COEF_W-1:0]  step_mag, new_step, old_step, clip_val;
    logic [DATA_W:0]    avg_diff, avg_diff_adj, avg_quot;
    logic               halve_last;

    //--------------------------------------------------------------------------
    // rams: tap weights, history line, step line
    //--------------------------------------------------------------------------
    ansf_ram #(.DEPTH(MAX_TAPS), .WIDTH(COEF_W)) u_weight_ram (
        .aclk    (aclk),
        .wr_en   (w_we),
        .wr_addr (w_waddr),
        .wr_data (w_wdata),
        .rd_addr (mac_raddr),
        .rd_data (w_rd)
    );

    ansf_ram #(.DEPTH(MAX_TAPS), .WIDTH(COEF_W)) u_history_ram (
        .aclk    (aclk),
        .wr_en   (h_we),
        .wr_addr (h_waddr),
        .wr_data (h_wdata),
        .rd_addr (mac_raddr),
        .rd_data (h_rd)
    );

    ansf_ram #(.DEPTH(MAX_TAPS), .WIDTH(COEF_W)) u_step_ram (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_addr (st_raddr),
        .rd_data (st_rd)
    );

    //--------------------------------------------------------------------------
    // configuration port, to be written only while no item is in flight
    //--------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_cfg_reg     <= ORDER_RST;
            frac_cfg_reg      <= FRAC_RST;
            new_adapt_cfg_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FILTER_ORDER:   order_cfg_reg     <= cfg_wr_data[ORDER_W-1:0];
                REG_FRAC_BITS:      frac_cfg_reg      <= cfg_wr_data[FRAC_W-1:0];
                REG_NEW_ADAPTATION: new_adapt_cfg_reg <= cfg_wr_data[0];
                default: ;          // unknown index ignored
            endcase
        end
    end

    // order outside the supported range snaps to the nearest end
    assign ord_cfg_wide = 32'(order_cfg_reg);
    always_comb begin
        if (ord_cfg_wide < 32'(MIN_ORDER)) begin
            ord_clamped = CNT_W'(MIN_ORDER);
        end else if (ord_cfg_wide > 32'(MAX_TAPS)) begin
            ord_clamped = CNT_W'(MAX_TAPS);
        end else begin
            ord_clamped = CNT_W'(ord_cfg_wide);
        end
    end

    //--------------------------------------------------------------------------
    // datapath pieces used by the sequencer
    //--------------------------------------------------------------------------
    assign ord_m1    = ord_reg - CNT_W'(1);
    assign mac_raddr = idx_reg[ADDR_W-1:0];

    // weight step: minus sign of residual times step entry, wrapping at 16 bits
    always_comb begin
        if (resid_reg[DATA_W-1]) begin
            w_upd = w_rd + st_rd;
        end else if (resid_reg != '0) begin
            w_upd = w_rd - st_rd;
        end else begin
            w_upd = w_rd;
        end
    end

    // halving position for this round
    always_comb begin
        if (new_adapt_cfg_reg) begin
            case (halve_cnt_reg)
                2'd0:    halve_pos = ord_reg - CNT_W'(NEW_HALVE_A);
                2'd1:    halve_pos = ord_reg - CNT_W'(NEW_HALVE_B);
                default: halve_pos = ord_reg - CNT_W'(NEW_HALVE_C);
            endcase
            halve_last = (halve_cnt_reg == NEW_HALVE_LAST);
        end else begin
            case (halve_cnt_reg)
                2'd0:    halve_pos = ord_reg - CNT_W'(OLD_HALVE_A);
                default: halve_pos = ord_reg - CNT_W'(OLD_HALVE_B);
            endcase
            halve_last = (halve_cnt_reg == OLD_HALVE_LAST);
        end
    end
    assign halve_addr = halve_pos[ADDR_W-1:0];
    assign st_raddr   = (state_reg == ST_HRD) ? halve_addr : mac_raddr;

    // rounding shift of the dot product; zero frac_bits leaves it alone
    assign rnd_term = (frac_cfg_reg == '0) ? '0 : (DATA_W'(1) << (frac_cfg_reg - FRAC_W'(1)));
    assign rnd_sum  = acc_reg + rnd_term;

    // magnitude, the most negative sample gives 2^31
    assign mag    = acc_reg[DATA_W-1] ? (~acc_reg + DATA_W'(1)) : acc_reg;
    assign mag_x3 = {2'b00, mag} + {1'b0, mag, 1'b0};
    assign avg_x3 = {2'b00, avg_reg} + {1'b0, avg_reg, 1'b0};
    assign avg_x4 = {avg_reg, 2'b00};
    assign le3    = ({2'b00, mag} <= avg_x3);
    assign le43   = (mag_x3 <= avg_x4);          // same as mag <= floor(4*avg/3)

    assign step_shift = {1'b0, le3} + {1'b0, le43};
    assign step_mag   = NEW_STEP_BASE >> step_shift;

    always_comb begin
        if (mag == '0) begin
            new_step = '0;
        end else if (acc_reg[DATA_W-1]) begin
            new_step = step_mag;
        end else begin
            new_step = -step_mag;
        end
        if (acc_reg == '0) begin
            old_step = '0;
        end else if (acc_reg[DATA_W-1]) begin
            old_step = OLD_STEP;
        end else begin
            old_step = -OLD_STEP;
        end
    end

    // saturate the sample to 16 bits for the history line
    always_comb begin
        if (!acc_reg[DATA_W-1] && (|acc_reg[DATA_W-2:COEF_W-1])) begin
            clip_val = {1'b0, {(COEF_W-1){1'b1}}};
        end else if (acc_reg[DATA_W-1] && !(&acc_reg[DATA_W-2:COEF_W-1])) begin
            clip_val = {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            clip_val = acc_reg[COEF_W-1:0];
        end
    end

    // mean update, division by 16 truncating toward zero
    assign avg_diff     = {1'b0, mag} - {1'b0, avg_reg};
    assign avg_diff_adj = avg_diff + (avg_diff[DATA_W] ? (DATA_W+1)'(15) : '0);
    assign avg_quot     = (DATA_W+1)'($signed(avg_diff_adj) >>> AVG_SHIFT);

    //--------------------------------------------------------------------------
    // sequencer: next state, ram controls and register updates
    //--------------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        ord_next       = ord_reg;
        item_pend_next = item_pend_reg;
        halve_cnt_next = halve_cnt_reg;
        avg_next       = avg_reg;
        v1_next        = 1'b0;
        idx1_next      = idx_reg[ADDR_W-1:0];
        v2_next        = v1_reg;
        prod_next      = DATA_W'($signed(w_rd)) * DATA_W'($signed(h_rd));
        acc_next       = acc_reg;
        resid_next     = resid_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        w_we     = 1'b0;
        w_waddr  = idx1_reg;
        w_wdata  = w_upd;
        h_we     = 1'b0;
        h_waddr  = idx1_reg - ADDR_W'(1);
        h_wdata  = h_rd;
        st_we    = 1'b0;
        st_waddr = idx1_reg - ADDR_W'(1);
        st_wdata = st_rd;

        unique case (state_reg)
            ST_CLEAR: begin
                // zero sweep over the whole depth
                w_we     = 1'b1;
                h_we     = 1'b1;
                st_we    = 1'b1;
                w_waddr  = idx_reg[ADDR_W-1:0];
                h_waddr  = idx_reg[ADDR_W-1:0];
                st_waddr = idx_reg[ADDR_W-1:0];
                w_wdata  = '0;
                h_wdata  = '0;
                st_wdata = '0;
                if (idx_reg == CNT_W'(MAX_TAPS - 1)) begin
                    idx_next       = '0;
                    avg_next       = '0;
                    item_pend_next = 1'b0;
                    state_next     = item_pend_reg ? ST_MAC : ST_IDLE;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    resid_next     = s_tdata;
                    ord_next       = ord_clamped;
                    acc_next       = '0;
                    idx_next       = '0;
                    halve_cnt_next = '0;
                    item_pend_next = 1'b1;
                    state_next     = s_tuser ? ST_CLEAR : ST_MAC;
                end
            end
            ST_MAC: begin
                // issue one tap read per cycle
                if (idx_reg < ord_reg) begin
                    v1_next  = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end
                // weight update in place, history and steps move down one slot
                if (v1_reg) begin
                    w_we = 1'b1;
                    if (idx1_reg != '0) begin
                        h_we  = 1'b1;
                        st_we = 1'b1;
                    end
                end
                if (v2_reg) begin
                    acc_next = acc_reg + prod_reg;
                end
                if ((idx_reg == ord_reg) && !v1_reg && !v2_reg) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                acc_next   = DATA_W'($signed(rnd_sum) >>> frac_cfg_reg);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                acc_next   = acc_reg + resid_reg;
                state_next = ST_NEWSTEP;
            end
            ST_NEWSTEP: begin
                h_we     = 1'b1;
                h_waddr  = ord_m1[ADDR_W-1:0];
                h_wdata  = clip_val;
                st_we    = 1'b1;
                st_waddr = ord_m1[ADDR_W-1:0];
                st_wdata = new_adapt_cfg_reg ? new_step : old_step;
                if (new_adapt_cfg_reg) begin
                    avg_next = avg_reg + avg_quot[DATA_W-1:0];
                end
                state_next = ST_HRD;
            end
            ST_HRD: begin
                state_next = ST_HWR;
            end
            ST_HWR: begin
                st_we    = 1'b1;
                st_waddr = halve_addr;
                st_wdata = halve16(st_rd);
                if (halve_last) begin
                    state_next = ST_OUT;
                end else begin
                    halve_cnt_next = halve_cnt_reg + 2'd1;
                    state_next     = ST_HRD;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            ord_reg       <= CNT_W'(MIN_ORDER);
            item_pend_reg <= 1'b0;
            halve_cnt_reg <= '0;
            avg_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            ord_reg       <= ord_next;
            item_pend_reg <= item_pend_next;
            halve_cnt_reg <= halve_cnt_next;
            avg_reg       <= avg_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx1_reg     <= idx1_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        resid_reg    <= resid_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    //--------------------------------------------------------------------------
    // assertions
    //--------------------------------------------------------------------------
    `ANSF_ASSERT_HOLDS(a_mac_idx_bound, state_reg == ST_MAC, idx_reg <= ord_reg, "tap index past order")
    `ANSF_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == ST_CLEAR || state_reg == ST_MAC, "transfer did not start a pass")
    `ANSF_ASSERT_HOLDS(a_halve_cnt, state_reg == ST_HRD || state_reg == ST_HWR, halve_cnt_reg <= NEW_HALVE_LAST, "halving count out of range")
    `ANSF_ASSERT_NEXT(a_out_load, state_reg == ST_OUT && (!m_tvalid || m_tready), m_tvalid && (m_tdata == $past(acc_reg)), "result not loaded")

endmodule

// ===== rtl/ansf_ram.sv =====
// simple dual-port ram, one write and one registered read per cycle
// depends on ansf_pkg for default sizes
module ansf_ram
    import ansf_pkg::*;
#(
    parameter int DEPTH = MAX_TAPS,
    parameter int WIDTH = COEF_W,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
